// ----- rtl/les_pkg.sv -----
// Shared types, codes and colour helpers for the LED strip effect engine.
package les_pkg;

	localparam int LED_W     = 6;
	localparam int CHAN_W    = 8;
	localparam int WORD_W    = 24;

	localparam logic [1:0] OP_TICK    = 2'd0;
	localparam logic [1:0] OP_RESTART = 2'd1;
	localparam logic [1:0] OP_WRITE   = 2'd2;

	localparam logic [2:0] MODE_OFF      = 3'd0;
	localparam logic [2:0] MODE_BREATH   = 3'd1;
	localparam logic [2:0] MODE_WATERFUL = 3'd2;
	localparam logic [2:0] MODE_TOUCH    = 3'd3;
	localparam logic [2:0] MODE_RAINBOW  = 3'd4;
	localparam logic [2:0] MODE_NORMAL   = 3'd5;
	localparam logic [2:0] MODE_CUSTOM   = 3'd6;

	localparam logic [1:0] REG_MODE   = 2'd0;
	localparam logic [1:0] REG_BRIGHT = 2'd1;
	localparam logic [1:0] REG_REPEAT = 2'd2;

	localparam logic [7:0]  RB_TOP     = 8'd42;
	localparam logic [9:0]  RB_CENTER  = 10'd128;
	localparam logic [9:0]  RB_STEP    = 10'd9;
	localparam logic [5:0]  RB_LAST    = 6'd17;
	// level*10/42 == (level*15605) >> 16 for any 8-bit level
	localparam logic [21:0] TENTH_MUL  = 22'd15605;
	localparam logic [7:0]  WF_LEVEL   = 8'h0F;

	typedef struct packed {
		logic [CHAN_W-1:0] level;
		logic [5:0]        tenth;
		logic [LED_W-1:0]  step_pos;
		logic [1:0]        step_ch;
	} anim_t;

	function automatic logic [WORD_W-1:0] grey_word(input logic [CHAN_W-1:0] v);
		return {v, v, v};
	endfunction

	function automatic logic [CHAN_W-1:0] dec_chan(input logic [CHAN_W-1:0] c);
		return (c != '0) ? c - 8'd1 : c;
	endfunction

	function automatic logic [WORD_W-1:0] touch_word(input logic [WORD_W-1:0] w);
		return {dec_chan(w[23:16]), dec_chan(w[15:8]), dec_chan(w[7:0])};
	endfunction

	// five-row layout; caller keeps the store for LEDs past the last row
	function automatic logic [WORD_W-1:0] rainbow_word(input logic [LED_W-1:0] idx,
		input logic [5:0] tenth);
		logic [LED_W-1:0]  start;
		logic [WORD_W-1:0] mask;
		logic [5:0]        pos;
		logic [5:0]        d;
		logic [9:0]        prod;
		logic [7:0]        v;
		if (idx <= 6'd3) begin
			start = 6'd0;  mask = 24'hFF00FF;
		end else if (idx <= 6'd7) begin
			start = 6'd4;  mask = 24'hFFFF00;
		end else if (idx <= 6'd10) begin
			start = 6'd8;  mask = 24'h00FFFF;
		end else if (idx <= 6'd13) begin
			start = 6'd11; mask = 24'h0000FF;
		end else begin
			start = 6'd14; mask = 24'hFF0000;
		end
		pos  = idx - start;
		d    = (pos >= tenth) ? pos - tenth : tenth - pos;
		prod = {4'b0, d} * RB_STEP;
		v    = 8'(RB_CENTER - prod);
		return {v, v, v} & mask;
	endfunction

endpackage

// ----- rtl/led_strip_effect_engine_core.sv -----
// Top level of the LED strip effect engine: sequencer, pixel store and colour stage.
//
// channel | direction | handshake            | payload
// in      | sink      | in_valid / in_stall  | op, led_sel, green_in, red_in, blue_in
// out     | source    | out_valid / out_stall| led_index, grb_word, last
// cfg     | sink      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A tick or restart holds in_stall after its accept while the store is read once per LED,
// and until the colour stage has taken the last read of the store RAM.
// A write pixel goes straight to the store write port when it is accepted.
// The store is cleared by per-LED valid bits, reset and restart clear them at once.
// out_stall holds the colour stage and a waiting store read; in_stall is high during a frame.
module led_strip_effect_engine_core #(
	parameter int NUM_LEDS = 18
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [4:0]  led_sel,
	input  logic [7:0]  green_in,
	input  logic [7:0]  red_in,
	input  logic [7:0]  blue_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [4:0]  led_index,
	output logic [23:0] grb_word,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import les_pkg::*;

	localparam int IDX_W = $clog2(NUM_LEDS);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t              state_q;
	logic [IDX_W-1:0]    rd_idx_q;
	logic [1:0]          op_q;
	logic                v_s1;
	logic [IDX_W-1:0]    idx_s1;
	logic [NUM_LEDS-1:0] vld_q;
	logic [2:0]          mode_q;
	logic [7:0]          bright_q;
	logic [7:0]          rep_q;
	logic                out_valid_q;
	logic [4:0]          out_idx_q;
	logic [WORD_W-1:0]   out_word_q;
	logic                out_last_q;

	logic                in_acc;
	logic                frame_start;
	logic                restart;
	logic                pix_we;
	logic                advance;
	logic                issue;
	logic                consume;
	logic                frame_end;
	logic [WORD_W-1:0]   ram_rdata;
	logic [WORD_W-1:0]   cur;
	logic [WORD_W-1:0]   word;
	logic [WORD_W-1:0]   new_word;
	logic                s1_we;
	logic                we;
	logic [IDX_W-1:0]    waddr;
	logic [WORD_W-1:0]   wdata;
	anim_t               anim;

	assign in_stall    = (state_q != ST_IDLE) || v_s1;
	assign in_acc      = in_valid && !in_stall;
	assign frame_start = in_acc && (op == OP_TICK || op == OP_RESTART);
	assign restart     = in_acc && (op == OP_RESTART);
	assign pix_we      = in_acc && (op == OP_WRITE) && (7'(led_sel) < 7'(NUM_LEDS));
	assign advance     = !out_valid_q || !out_stall;
	assign issue       = (state_q == ST_RUN) && (advance || !v_s1);
	assign consume     = v_s1 && advance;
	assign frame_end   = consume && (op_q == OP_TICK) && (idx_s1 == IDX_W'(NUM_LEDS - 1));
	assign cfg_ready   = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_OFF;
			bright_q <= 8'd64;
			rep_q    <= 8'd12;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MODE:   mode_q   <= cfg_data[2:0];
				REG_BRIGHT: bright_q <= cfg_data;
				REG_REPEAT: rep_q    <= cfg_data;
				default:    mode_q   <= mode_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rd_idx_q <= '0;
			op_q     <= OP_TICK;
			v_s1     <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (frame_start) begin
						state_q  <= ST_RUN;
						rd_idx_q <= '0;
						op_q     <= op;
					end
				end
				ST_RUN: begin
					if (issue) begin
						rd_idx_q <= rd_idx_q + 1'b1;
						if (rd_idx_q == IDX_W'(NUM_LEDS - 1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (issue) begin
				v_s1 <= 1'b1;
			end else if (advance) begin
				v_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			idx_s1 <= rd_idx_q;
		end
	end

	les_ram #(
		.WIDTH (WORD_W),
		.DEPTH (NUM_LEDS)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (issue),
		.raddr (rd_idx_q),
		.rdata (ram_rdata)
	);

	les_anim #(
		.NUM_LEDS (NUM_LEDS)
	) u_anim (
		.clk          (clk),
		.arst_n       (arst_n),
		.mode         (mode_q),
		.brightness   (bright_q),
		.repeat_ticks (rep_q),
		.frame_end    (frame_end),
		.restart      (restart),
		.anim         (anim)
	);

	assign cur = vld_q[idx_s1] ? ram_rdata : '0;

	always_comb begin
		word     = '0;
		new_word = cur;
		s1_we    = 1'b0;
		if (op_q == OP_TICK) begin
			unique case (mode_q)
				MODE_BREATH: begin
					new_word = grey_word(anim.level);
					word     = new_word;
					s1_we    = 1'b1;
				end
				MODE_WATERFUL: begin
					if (LED_W'(idx_s1) == anim.step_pos) begin
						unique case (anim.step_ch)
							2'd0:    word = {WF_LEVEL, 16'h0};
							2'd1:    word = {8'h0, WF_LEVEL, 8'h0};
							default: word = {16'h0, WF_LEVEL};
						endcase
					end
				end
				MODE_TOUCH: begin
					word     = cur;
					new_word = touch_word(cur);
					s1_we    = 1'b1;
				end
				MODE_RAINBOW: begin
					word = cur;
					if (LED_W'(idx_s1) <= RB_LAST) begin
						new_word = rainbow_word(LED_W'(idx_s1), anim.tenth);
						s1_we    = 1'b1;
					end
				end
				MODE_NORMAL: begin
					new_word = grey_word(bright_q);
					word     = new_word;
					s1_we    = 1'b1;
				end
				MODE_CUSTOM: word = cur;
				default:     word = '0;
			endcase
		end
	end

	assign we    = pix_we || (consume && s1_we);
	assign waddr = pix_we ? IDX_W'(led_sel) : idx_s1;
	assign wdata = pix_we ? {green_in, red_in, blue_in} : new_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (restart) begin
			vld_q <= '0;
		end else if (we) begin
			vld_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (consume) begin
			out_idx_q  <= 5'(idx_s1);
			out_word_q <= word;
			out_last_q <= (idx_s1 == IDX_W'(NUM_LEDS - 1));
		end
	end

	assign out_valid = out_valid_q;
	assign led_index = out_idx_q;
	assign grb_word  = out_word_q;
	assign last      = out_last_q;

	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last) |-> (led_index == 5'(NUM_LEDS - 1)))
		else $error("last flag on wrong LED");
	a_port_free: assert property (@(posedge clk) disable iff (!arst_n)
		!(pix_we && v_s1))
		else $error("pixel write collides with frame write-back");
	a_read_lands: assert property (@(posedge clk) disable iff (!arst_n)
		issue |=> v_s1)
		else $error("store read lost");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> !in_acc)
		else $error("item accepted during frame");

endmodule

// ----- rtl/les_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read.
module les_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 18
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/les_anim.sv -----
// Animation counters: breath/rainbow level, waterful step and tick divider.
module les_anim #(
	parameter int NUM_LEDS = 18
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [2:0]    mode,
	input  logic [7:0]    brightness,
	input  logic [7:0]    repeat_ticks,
	input  logic          frame_end,
	input  logic          restart,
	output les_pkg::anim_t anim
);
	import les_pkg::*;

	logic [7:0]       level_q, level_d;
	logic             ramp_q, ramp_d;
	logic [7:0]       sub_q, sub_d;
	logic [LED_W-1:0] pos_q, pos_d;
	logic [1:0]       ch_q, ch_d;
	logic [5:0]       tenth_q;
	logic [21:0]      tenth_prod;
	logic [7:0]       top;
	logic [7:0]       lv;
	logic [7:0]       rep;
	logic [7:0]       sub_inc;

	always_comb begin
		level_d = level_q;
		ramp_d  = ramp_q;
		sub_d   = sub_q;
		pos_d   = pos_q;
		ch_d    = ch_q;
		top     = (mode == MODE_BREATH) ? brightness : RB_TOP;
		lv      = ramp_q ? level_q - 8'd1 : level_q + 8'd1;
		rep     = (repeat_ticks == '0) ? 8'd1 : repeat_ticks;
		sub_inc = sub_q + 8'd1;
		priority if (restart) begin
			level_d = '0;
			ramp_d  = 1'b0;
			sub_d   = '0;
			pos_d   = '0;
			ch_d    = '0;
		end else if (frame_end && (mode == MODE_BREATH || mode == MODE_RAINBOW)) begin
			level_d = lv;
			if (lv == top || lv == '0) begin
				ramp_d = ~ramp_q;
			end
		end else if (frame_end && mode == MODE_WATERFUL) begin
			if (sub_inc >= rep || sub_inc == '0) begin
				sub_d = '0;
				if (pos_q == LED_W'(NUM_LEDS - 1)) begin
					pos_d = '0;
					ch_d  = (ch_q == 2'd2) ? 2'd0 : ch_q + 2'd1;
				end else begin
					pos_d = pos_q + 1'b1;
				end
			end else begin
				sub_d = sub_inc;
			end
		end else begin
			level_d = level_q;
		end
	end

	assign tenth_prod = 22'(level_d) * TENTH_MUL;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
			ramp_q  <= 1'b0;
			sub_q   <= '0;
			pos_q   <= '0;
			ch_q    <= '0;
			tenth_q <= '0;
		end else begin
			level_q <= level_d;
			ramp_q  <= ramp_d;
			sub_q   <= sub_d;
			pos_q   <= pos_d;
			ch_q    <= ch_d;
			tenth_q <= tenth_prod[21:16];
		end
	end

	assign anim.level    = level_q;
	assign anim.tenth    = tenth_q;
	assign anim.step_pos = pos_q;
	assign anim.step_ch  = ch_q;

	a_ch_range: assert property (@(posedge clk) disable iff (!arst_n) ch_q != 2'd3)
		else $error("waterful channel out of range");
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= LED_W'(NUM_LEDS - 1))
		else $error("waterful position out of range");
	a_restart_clr: assert property (@(posedge clk) disable iff (!arst_n)
		restart |=> (level_q == '0 && sub_q == '0 && pos_q == '0 && ch_q == '0))
		else $error("restart left counters set");

endmodule
